/* design/qfa_pkg.sv */
// Shared types and constants for the Q16.16 fixed-point arithmetic unit.
package qfa_pkg;

	localparam int unsigned FracBitsDefault = 16;

	localparam logic [2:0] KIND_ADD     = 3'd0;
	localparam logic [2:0] KIND_SUB     = 3'd1;
	localparam logic [2:0] KIND_MUL     = 3'd2;
	localparam logic [2:0] KIND_DIV     = 3'd3;
	localparam logic [2:0] KIND_SHL     = 3'd4;
	localparam logic [2:0] KIND_FRAC    = 3'd5;
	localparam logic [2:0] KIND_ROUND   = 3'd6;
	localparam logic [2:0] KIND_PERCENT = 3'd7;

	localparam logic signed [31:0] PCT_MUL = 32'sd41943;
	localparam logic [63:0]        PCT_ADD = 64'd32;
	localparam int unsigned        PCT_SHIFT = 6;

	// side information that rides along with the divider datapath
	typedef struct packed {
		logic [2:0]  kind;
		logic        div_neg;
		logic        dbz;
		logic [31:0] fast_res;
		logic        fast_ovf;
		logic [63:0] prod;
	} ctl_t;

endpackage

/* design/q16_16_fixed_point_alu_core.sv */
// Top level of the Q16.16 fixed-point arithmetic unit: stage chain and result stage.
// Path from start to done, the same for every kind: prep stage, divider stage chain, result register.
// Throughput: one item per cycle; busy is always low and results leave in issue order.
// The depth is set by the divider, which resolves one quotient bit per register stage.
// Reset (arst_n low) clears every valid bit at once; payload registers are not reset.
// The receiver cannot stall: done pulses for one cycle with result and flags.
module q16_16_fixed_point_alu_core #(
	parameter int unsigned FRAC_BITS = qfa_pkg::FracBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        done,
	output logic [31:0] result,
	output logic        overflow,
	output logic        divide_by_zero
);
	import qfa_pkg::*;

	// dividend width: magnitude of operand_a shifted up by the binary point
	localparam int unsigned W   = 32 + FRAC_BITS;
	localparam int unsigned LAT = W + 2;

	logic             vld [0:W];
	ctl_t             ctl [0:W];
	logic [31:0]      rem [0:W];
	logic [W-1:0]     nq  [0:W];
	logic [31:0]      dsr [0:W];

	// every stage advances each cycle; nothing holds items off
	assign busy = 1'b0;

	qfa_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.kind(kind), .operand_a(operand_a), .operand_b(operand_b),
		.valid_s1(vld[0]), .ctl_s1(ctl[0]), .rem_s1(rem[0]),
		.nq_s1(nq[0]), .dsr_s1(dsr[0])
	);

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < W; i++) begin : g_div
		qfa_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
			.clk(clk), .arst_n(arst_n),
			.valid_in(vld[i]), .ctl_in(ctl[i]), .rem_in(rem[i]),
			.nq_in(nq[i]), .dsr_in(dsr[i]),
			.valid_s1(vld[i+1]), .ctl_s1(ctl[i+1]), .rem_s1(rem[i+1]),
			.nq_s1(nq[i+1]), .dsr_s1(dsr[i+1])
		);
	end

	// result stage: finish multiply, percent and divide, pick the answer
	ctl_t         c;
	logic [W-1:0] quo;
	logic [W:0]   squo;
	logic [63:0]  pct;
	logic [63:0]  mhi;
	logic [31:0]  res_d;
	logic         ovf_d, dbz_d;

	always_comb begin
		c    = ctl[W];
		quo  = nq[W];
		squo = c.div_neg ? ((W+1)'(0) - {1'b0, quo}) : {1'b0, quo};
		pct  = c.prod + PCT_ADD;
		// high word of product: bits from 31+FRAC_BITS up must all match the sign
		mhi  = $signed(c.prod) >>> (31 + FRAC_BITS);
		res_d = c.fast_res;
		ovf_d = c.fast_ovf;
		dbz_d = 1'b0;
		unique case (c.kind)
			KIND_MUL: begin
				res_d = 32'(c.prod >> FRAC_BITS);
				ovf_d = !((mhi == 64'd0) || (mhi == {64{1'b1}}));
			end
			KIND_PERCENT: begin
				res_d = 32'(pct >> PCT_SHIFT);
				ovf_d = 1'b0;
			end
			KIND_DIV: begin
				if (c.dbz) begin
					res_d = 32'd0;
					ovf_d = 1'b0;
					dbz_d = 1'b1;
				end else begin
					res_d = squo[31:0];
					if (c.div_neg) begin
						ovf_d = (|quo[W-1:32]) || (quo[31] && (|quo[30:0]));
					end else begin
						ovf_d = |quo[W-1:31];
					end
				end
			end
			default: begin
			end
		endcase
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld[W];
		end
	end

	always_ff @(posedge clk) begin
		result         <= res_d;
		overflow       <= ovf_d;
		divide_by_zero <= dbz_d;
	end

	assign done = done_q;

	// every result traces back to a matching start at the input
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without matching start");

	// divide by zero forces a zero result and no overflow
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> (result == 32'd0 && !overflow))
		else $error("divide by zero result not clean");

	// divide by zero flag only ever comes from a divide item
	a_dbz_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> ($past(kind, LAT) == KIND_DIV))
		else $error("divide by zero flag on non-divide item");

endmodule

/* design/qfa_prep.sv */
// First stage: operand decode, add/sub/shift/frac/round results, multiplier, divider setup.
module qfa_prep #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [2:0]              kind,
	input  logic [31:0]             operand_a,
	input  logic [31:0]             operand_b,
	output logic                    valid_s1,
	output qfa_pkg::ctl_t           ctl_s1,
	output logic [31:0]             rem_s1,
	output logic [32+FRAC_BITS-1:0] nq_s1,
	output logic [31:0]             dsr_s1
);
	import qfa_pkg::*;

	logic [32:0] sum, dif, a_ext, b_ext, mag_a, mag_b, rnd_t, rnd_q, rnd_r;
	logic [63:0] shl;
	logic [31:0] frac_mask, frac_v;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod;
	ctl_t ctl;

	always_comb begin
		a_ext = {operand_a[31], operand_a};
		b_ext = {operand_b[31], operand_b};
		sum   = a_ext + b_ext;
		dif   = a_ext - b_ext;
		shl   = {{32{operand_a[31]}}, operand_a} << operand_b[4:0];
		mag_a = operand_a[31] ? (33'd0 - a_ext) : a_ext;
		mag_b = operand_b[31] ? (33'd0 - b_ext) : b_ext;
		frac_mask = (32'd1 << FRAC_BITS) - 32'd1;
		frac_v = operand_a & frac_mask;
		if (operand_a[31] && (frac_v != 32'd0)) begin
			frac_v = frac_v | ~frac_mask;
		end
		rnd_t = mag_a + (33'd1 << (FRAC_BITS - 1));
		rnd_q = rnd_t >> FRAC_BITS;
		rnd_r = operand_a[31] ? (33'd0 - rnd_q) : rnd_q;
		mul_b = (kind == KIND_PERCENT) ? PCT_MUL : $signed(operand_b);
		prod  = $signed(operand_a) * mul_b;

		ctl.kind     = kind;
		ctl.div_neg  = operand_a[31] ^ operand_b[31];
		ctl.dbz      = (kind == KIND_DIV) && (operand_b == 32'd0);
		ctl.prod     = prod;
		ctl.fast_res = 32'd0;
		ctl.fast_ovf = 1'b0;
		unique case (kind)
			KIND_ADD: begin
				ctl.fast_res = sum[31:0];
				ctl.fast_ovf = sum[32] ^ sum[31];
			end
			KIND_SUB: begin
				ctl.fast_res = dif[31:0];
				ctl.fast_ovf = dif[32] ^ dif[31];
			end
			KIND_SHL: begin
				ctl.fast_res = shl[31:0];
				ctl.fast_ovf = !((&shl[63:31]) || !(|shl[63:31]));
			end
			KIND_FRAC: begin
				ctl.fast_res = frac_v;
			end
			KIND_ROUND: begin
				ctl.fast_res = rnd_r[31:0];
				ctl.fast_ovf = rnd_t[32] | rnd_t[31];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl;
		rem_s1 <= 32'd0;
		nq_s1  <= {mag_a[31:0], {FRAC_BITS{1'b0}}};
		dsr_s1 <= mag_b[31:0];
	end

endmodule

/* design/qfa_div_step.sv */
// One restoring-division stage: one quotient bit per register stage.
module qfa_div_step #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_in,
	input  qfa_pkg::ctl_t           ctl_in,
	input  logic [31:0]             rem_in,
	input  logic [32+FRAC_BITS-1:0] nq_in,
	input  logic [31:0]             dsr_in,
	output logic                    valid_s1,
	output qfa_pkg::ctl_t           ctl_s1,
	output logic [31:0]             rem_s1,
	output logic [32+FRAC_BITS-1:0] nq_s1,
	output logic [31:0]             dsr_s1
);
	import qfa_pkg::*;

	localparam int unsigned W = 32 + FRAC_BITS;

	logic [32:0] rem2;
	logic [33:0] diff;
	logic        ge;

	always_comb begin
		rem2 = {rem_in, nq_in[W-1]};
		diff = {1'b0, rem2} - {2'b00, dsr_in};
		ge   = !diff[33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_in;
		dsr_s1 <= dsr_in;
		rem_s1 <= ge ? diff[31:0] : rem2[31:0];
		nq_s1  <= {nq_in[W-2:0], ge};
	end

endmodule
